FILE: rtl/rhv_pkg.sv
// types, codes and fixed constants shared by the readout header validator
`timescale 1ns / 1ps
package rhv_pkg;

	// header geometry
	localparam int unsigned PAD_BYTES    = 2;
	localparam int unsigned HEADER_BYTES = 30;
	localparam int unsigned COOKIE_BYTES = 4;
	localparam int unsigned MAX_DATAGRAM = 8972;

	localparam logic [15:0] MIN_SIZE     = 16'(COOKIE_BYTES + PAD_BYTES);
	localparam logic [15:0] MAX_SIZE     = 16'(MAX_DATAGRAM);
	localparam logic [15:0] HDR_SIZE     = 16'(HEADER_BYTES);
	localparam logic [31:0] COOKIE_V0    = 32'h0053_5345;

	// status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BUFFER = 2'd1;
	localparam logic [1:0] ST_SIZE   = 2'd2;
	localparam logic [1:0] ST_HEADER = 2'd3;

	// error kinds
	localparam logic [2:0] KIND_NONE    = 3'd0;
	localparam logic [2:0] KIND_BUFFER  = 3'd1;
	localparam logic [2:0] KIND_SIZE    = 3'd2;
	localparam logic [2:0] KIND_VERSION = 3'd3;
	localparam logic [2:0] KIND_TYPE    = 3'd4;
	localparam logic [2:0] KIND_QUEUE   = 3'd5;

	// one header item
	typedef struct packed {
		logic        buffer_present;
		logic [15:0] packet_size;
		logic [31:0] cookie_version;
		logic [15:0] total_length;
		logic [7:0]  type_subtype;
		logic [7:0]  queue_id;
		logic [31:0] seq_num;
	} hdr_item_t;

	// one result item
	typedef struct packed {
		logic [1:0]  status;
		logic [2:0]  error_kind;
		logic        seq_mismatch;
		logic [31:0] expected_seq;
		logic [15:0] payload_length;
	} res_item_t;

	// outcome of the header checks
	typedef struct packed {
		logic        ok;
		logic [1:0]  status;
		logic [2:0]  error_kind;
		logic [15:0] payload_length;
	} verdict_t;

endpackage

FILE: rtl/rhv_if.sv
// valid/ready channel interfaces for header items, result items and config writes
`timescale 1ns / 1ps
interface rhv_hdr_if;
	logic               valid;
	logic               ready;
	rhv_pkg::hdr_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rhv_res_if;
	logic               valid;
	logic               ready;
	rhv_pkg::res_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rhv_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/rhv_check.sv
// ordered header checks giving status, error kind and payload length
`timescale 1ns / 1ps
module rhv_check #(
	parameter int QUEUES = 32
) (
	input  rhv_pkg::hdr_item_t hdr,
	input  logic [7:0]         expected_type,
	output rhv_pkg::verdict_t  verdict
);

	logic queue_ok;

	// queue range, compared one bit wider so that 256 queues fit
	assign queue_ok = ({1'b0, hdr.queue_id} < 9'(QUEUES));

	// first failing check wins
	always_comb begin
		verdict.ok             = 1'b0;
		verdict.status         = rhv_pkg::ST_OK;
		verdict.error_kind     = rhv_pkg::KIND_NONE;
		verdict.payload_length = '0;
		if (!hdr.buffer_present || hdr.packet_size == '0) begin
			verdict.status     = rhv_pkg::ST_BUFFER;
			verdict.error_kind = rhv_pkg::KIND_BUFFER;
		end else if (hdr.packet_size < rhv_pkg::MIN_SIZE ||
				hdr.packet_size > rhv_pkg::MAX_SIZE) begin
			verdict.status     = rhv_pkg::ST_SIZE;
			verdict.error_kind = rhv_pkg::KIND_SIZE;
		end else if (hdr.cookie_version != rhv_pkg::COOKIE_V0) begin
			verdict.status     = rhv_pkg::ST_HEADER;
			verdict.error_kind = rhv_pkg::KIND_VERSION;
		end else if (hdr.packet_size < rhv_pkg::HDR_SIZE) begin
			verdict.status     = rhv_pkg::ST_SIZE;
			verdict.error_kind = rhv_pkg::KIND_SIZE;
		end else if (hdr.packet_size < hdr.total_length ||
				hdr.total_length < rhv_pkg::HDR_SIZE) begin
			verdict.status     = rhv_pkg::ST_SIZE;
			verdict.error_kind = rhv_pkg::KIND_SIZE;
		end else if (hdr.type_subtype != expected_type) begin
			verdict.status     = rhv_pkg::ST_HEADER;
			verdict.error_kind = rhv_pkg::KIND_TYPE;
		end else if (!queue_ok) begin
			verdict.status     = rhv_pkg::ST_HEADER;
			verdict.error_kind = rhv_pkg::KIND_QUEUE;
		end else begin
			verdict.ok             = 1'b1;
			verdict.payload_length = hdr.total_length - rhv_pkg::HDR_SIZE;
		end
	end

endmodule

FILE: rtl/rhv_seq_table.sv
// per-queue expected sequence memory with valid bits and write forwarding
`timescale 1ns / 1ps
module rhv_seq_table #(
	parameter int QUEUES = 32,
	parameter int AW     = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [31:0]   wr_data,
	output logic [31:0]   held
);

	logic [31:0]     mem [QUEUES];
	logic [QUEUES-1:0] valid_q;
	logic [31:0]     rd_data_s1;
	logic            rd_valid_s1;
	logic            fwd_s1;
	logic [31:0]     fwd_data_s1;

	// storage, read-before-write at one edge
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	// written flags, cleared at reset so unwritten entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// read-side flags and bypass of a write landing with the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			fwd_s1      <= 1'b0;
		end else if (rd_en) begin
			rd_valid_s1 <= valid_q[rd_addr];
			fwd_s1      <= wr_en && (wr_addr == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			fwd_data_s1 <= wr_data;
		end
	end

	assign held = fwd_s1 ? fwd_data_s1 : (rd_valid_s1 ? rd_data_s1 : '0);

endmodule

FILE: rtl/readout_header_validator_core.sv
// top level of the readout header validator
`timescale 1ns / 1ps
// Checks the extracted header fields of one readout datagram per item and
// tracks the sequence number of each output queue.
// Channels: hdr (header items in), res (one result item out per header
// item), cfg (write of the expected type byte, always ready). All use
// valid/ready; an item moves at a rising edge with both high.
// Path: stage 1 register, then result register. Throughput: one item per
// cycle while res.ready is high. The sequence memory is read on accept and
// written back when a passing item leaves stage 1; a back-to-back item on
// the same queue takes the new value via a bypass register; no bubble.
// Reset: all written flags of the sequence memory clear at once, so every
// queue expects zero; expected type resets to zero. No clearing pass.
// Stall: the result register holds while res.ready is low; the check stage
// keeps accepting until it is also full, then hdr.ready drops.
module readout_header_validator_core #(
	parameter int QUEUES = 32
) (
	input logic          clk,
	input logic          arst_n,
	rhv_hdr_if.sink      hdr,
	rhv_res_if.source    res,
	rhv_cfg_if.sink      cfg
);

	localparam int AW = (QUEUES > 1) ? $clog2(QUEUES) : 1;

	logic [7:0]         expected_type_q;
	rhv_pkg::verdict_t  verdict;
	logic               hdr_take;
	logic               valid_s1;
	rhv_pkg::verdict_t  verdict_s1;
	logic [31:0]        seq_s1;
	logic [AW-1:0]      queue_s1;
	logic               adv_s1;
	logic [31:0]        held;
	logic               out_valid_q;
	rhv_pkg::res_item_t out_q;

	// config register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_type_q <= '0;
		end else if (cfg.valid) begin
			expected_type_q <= cfg.data;
		end
	end

	// header checks at acceptance
	rhv_check #(.QUEUES(QUEUES)) u_check (
		.hdr           (hdr.data),
		.expected_type (expected_type_q),
		.verdict       (verdict)
	);

	assign adv_s1    = valid_s1 && (!out_valid_q || res.ready);
	assign hdr.ready = !valid_s1 || adv_s1;
	assign hdr_take  = hdr.valid && hdr.ready;

	// sequence memory: read on accept, write back as ok items leave stage 1
	rhv_seq_table #(.QUEUES(QUEUES), .AW(AW)) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (hdr_take),
		.rd_addr (hdr.data.queue_id[AW-1:0]),
		.wr_en   (adv_s1 && verdict_s1.ok),
		.wr_addr (queue_s1),
		.wr_data (seq_s1 + 32'd1),
		.held    (held)
	);

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (hdr.ready) begin
			valid_s1 <= hdr.valid;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (hdr_take) begin
			verdict_s1 <= verdict;
			seq_s1     <= hdr.data.seq_num;
			queue_s1   <= hdr.data.queue_id[AW-1:0];
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || res.ready) begin
			out_valid_q <= valid_s1;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_q.status         <= verdict_s1.status;
			out_q.error_kind     <= verdict_s1.error_kind;
			out_q.seq_mismatch   <= verdict_s1.ok && (held != seq_s1);
			out_q.expected_seq   <= verdict_s1.ok ? held : '0;
			out_q.payload_length <= verdict_s1.payload_length;
		end
	end

	assign res.valid = out_valid_q;
	assign res.data  = out_q;

endmodule
